>>> rtl/spi_pkg.sv
`default_nettype none

package spi_pkg;

  // field widths
  localparam int unsigned XYW       = 32;
  localparam int unsigned HW        = 16;
  localparam int unsigned RESW      = 23;
  localparam int unsigned MAX_STEPS = 63;

  // reset spacing, 0.1 m in Q16.16
  localparam logic [RESW-1:0] RES_RESET = 23'd6554;

  // heading limit in Q3.13
  localparam logic signed [HW-1:0] HEAD_MAX = 16'sd25736;

  // cordic datapath widths
  localparam int unsigned CXW = 56;
  localparam int unsigned CZW = 36;
  localparam logic signed [CZW-1:0] PI_Q30 = 36'sd3373259426;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ABS,
    ST_SQX,
    ST_SQY,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_CMP,
    ST_NDIV_GO,
    ST_NDIV_WAIT,
    ST_XDIV_GO,
    ST_XDIV_WAIT,
    ST_YDIV_GO,
    ST_YDIV_WAIT,
    ST_CORD_GO,
    ST_CORD_WAIT,
    ST_EMIT_START,
    ST_EMIT_END,
    ST_EMIT_PT
  } spi_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_NORM,
    CS_ITER,
    CS_FIN
  } spi_cstate_e;

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    begin
      unique case (idx)
        5'd0:  v = 32'h3243F6A8;
        5'd1:  v = 32'h1DAC6705;
        5'd2:  v = 32'h0FADBAFC;
        5'd3:  v = 32'h07F56EA6;
        5'd4:  v = 32'h03FEAB76;
        5'd5:  v = 32'h01FFD55B;
        5'd6:  v = 32'h00FFFAAA;
        5'd7:  v = 32'h007FFF55;
        5'd8:  v = 32'h003FFFEA;
        5'd9:  v = 32'h001FFFFD;
        5'd10: v = 32'h000FFFFF;
        5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF;
        5'd13: v = 32'h0001FFFF;
        5'd14: v = 32'h0000FFFF;
        5'd15: v = 32'h00007FFF;
        5'd16: v = 32'h00003FFF;
        5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF;
        5'd19: v = 32'h000007FF;
        5'd20: v = 32'h000003FF;
        5'd21: v = 32'h000001FF;
        5'd22: v = 32'h000000FF;
        5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F;
        5'd25: v = 32'h0000001F;
        5'd26: v = 32'h0000000F;
        5'd27: v = 32'h00000008;
        5'd28: v = 32'h00000004;
        5'd29: v = 32'h00000002;
        5'd30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/segment_pose_interpolator.sv
`default_nettype none

// Interpolates poses along one path segment per input word. The length is
// found by a bit-serial square root, the step count and the two per-step
// increments by one shared restoring divider, and the heading by a
// vectoring cordic (a coarse normalize, then 32 rotations). After the
// compute it emits one pose per cycle while the output side takes them; a
// short segment skips the divisions and the cordic. The block takes no new
// word until the last pose of the segment is in the output register.
module segment_pose_interpolator
  import spi_pkg::*;
#(
  parameter int unsigned MAX_STEPS_P = MAX_STEPS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [RESW-1:0]       cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic signed [XYW-1:0] start_x_i,
  input  wire logic signed [XYW-1:0] start_y_i,
  input  wire logic signed [HW-1:0]  start_heading_i,
  input  wire logic signed [XYW-1:0] end_x_i,
  input  wire logic signed [XYW-1:0] end_y_i,
  input  wire logic signed [HW-1:0]  end_heading_i,
  input  wire logic                  first_segment_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [XYW-1:0]      pose_x_o,
  output logic signed [XYW-1:0]      pose_y_o,
  output logic signed [HW-1:0]       pose_heading_o,
  output logic                       last_of_run_o,
  output logic                       steps_clamped_o
);

  localparam int unsigned NW = $clog2(MAX_STEPS_P + 1);
  localparam int unsigned DW = 34;

  spi_state_e state_q, state_d;

  logic [RESW-1:0]        res_q;
  logic signed [XYW-1:0]  sx_q, sy_q, ex_q, ey_q;
  logic signed [HW-1:0]   sh_q, eh_q;
  logic                   first_q;
  logic signed [32:0]     dx_q, dy_q;
  logic [32:0]            adx_q, ady_q;
  logic [65:0]            sq_q;
  logic [32:0]            len_q;
  logic [NW-1:0]          n_q, i_q;
  logic                   clamp_q;
  logic [32:0]            q0x_q, q0y_q, qx_q, qy_q;
  logic [NW:0]            r0x_q, r0y_q, rx_q, ry_q;
  logic signed [HW-1:0]   head_q;

  logic                   out_valid_q;
  logic signed [XYW-1:0]  pose_x_q, pose_y_q;
  logic signed [HW-1:0]   pose_h_q;
  logic                   last_q, cl_q;

  logic [RESW-1:0]        res_eff;
  logic                   out_free, in_acc;
  logic                   sqrt_go, div_go, cord_go;
  logic [32:0]            root;
  logic                   sqrt_done, div_done, cord_done;
  logic [DW-1:0]          div_a, div_quo;
  logic [RESW-1:0]        div_b, div_rem;
  logic signed [HW-1:0]   cord_head;
  logic                   load_start, load_end, load_pt;

  logic [32:0]            sq_op;
  logic [65:0]            sq_prod;

  logic [NW+1:0]          rsx, rsy;
  logic [NW:0]            twon;
  logic                   gex, gey;
  logic [32:0]            qx_n, qy_n;
  logic [XYW-1:0]         offx, offy;
  logic [NW-1:0]          i_n;

  assign res_eff  = (res_q == '0) ? RESW'(1) : res_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && in_ready_o;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_q <= RES_RESET;
    else if (cfg_we_i) res_q <= cfg_wdata_i;
  end

  // one squarer shared by both axes
  assign sq_op   = (state_q == ST_SQY) ? ady_q : adx_q;
  assign sq_prod = {33'b0, sq_op} * {33'b0, sq_op};

  spi_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_go),
    .rad_i  (sq_q),
    .root_o (root),
    .done_o (sqrt_done)
  );

  // divider operand select
  always_comb begin
    div_a = {1'b0, adx_q};
    div_b = RESW'(n_q);
    case (state_q)
      ST_NDIV_GO: begin
        div_a = DW'(len_q) + DW'(res_eff) - DW'(1);
        div_b = res_eff;
      end
      ST_YDIV_GO: div_a = {1'b0, ady_q};
      default: ;
    endcase
  end

  spi_div #(.DW(DW), .VW(RESW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_go),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .quo_o     (div_quo),
    .rem_o     (div_rem),
    .done_o    (div_done)
  );

  spi_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_go),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .head_o (cord_head),
    .done_o (cord_done)
  );

  // next point: running quotient and remainder of (2*i*|d| + n) / 2n
  assign twon = {n_q, 1'b0};
  assign rsx  = {1'b0, rx_q} + {1'b0, r0x_q};
  assign rsy  = {1'b0, ry_q} + {1'b0, r0y_q};
  assign gex  = (rsx >= {1'b0, twon});
  assign gey  = (rsy >= {1'b0, twon});
  assign qx_n = qx_q + q0x_q + 33'(gex);
  assign qy_n = qy_q + q0y_q + 33'(gey);
  assign offx = dx_q[32] ? (~qx_n[XYW-1:0] + XYW'(1)) : qx_n[XYW-1:0];
  assign offy = dy_q[32] ? (~qy_n[XYW-1:0] + XYW'(1)) : qy_n[XYW-1:0];
  assign i_n  = i_q + NW'(1);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    sqrt_go    = 1'b0;
    div_go     = 1'b0;
    cord_go    = 1'b0;
    load_start = 1'b0;
    load_end   = 1'b0;
    load_pt    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_ABS;
      end
      ST_ABS: state_d = ST_SQX;
      ST_SQX: state_d = ST_SQY;
      ST_SQY: state_d = ST_SQRT_GO;
      ST_SQRT_GO: begin
        sqrt_go = 1'b1;
        state_d = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: if (sqrt_done) state_d = ST_CMP;
      ST_CMP: begin
        if (len_q < 33'(res_eff)) state_d = first_q ? ST_EMIT_START : ST_EMIT_END;
        else                      state_d = ST_NDIV_GO;
      end
      ST_NDIV_GO: begin
        div_go  = 1'b1;
        state_d = ST_NDIV_WAIT;
      end
      ST_NDIV_WAIT: if (div_done) state_d = ST_XDIV_GO;
      ST_XDIV_GO: begin
        div_go  = 1'b1;
        state_d = ST_XDIV_WAIT;
      end
      ST_XDIV_WAIT: if (div_done) state_d = ST_YDIV_GO;
      ST_YDIV_GO: begin
        div_go  = 1'b1;
        state_d = ST_YDIV_WAIT;
      end
      ST_YDIV_WAIT: if (div_done) state_d = ST_CORD_GO;
      ST_CORD_GO: begin
        cord_go = 1'b1;
        state_d = ST_CORD_WAIT;
      end
      ST_CORD_WAIT: if (cord_done) state_d = first_q ? ST_EMIT_START : ST_EMIT_PT;
      ST_EMIT_START: begin
        if (out_free) begin
          load_start = 1'b1;
          state_d    = (len_q < 33'(res_eff)) ? ST_EMIT_END : ST_EMIT_PT;
        end
      end
      ST_EMIT_END: begin
        if (out_free) begin
          load_end = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_EMIT_PT: begin
        if (out_free) begin
          load_pt = 1'b1;
          if (i_n == n_q) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // segment datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sx_q    <= start_x_i;
      sy_q    <= start_y_i;
      sh_q    <= start_heading_i;
      ex_q    <= end_x_i;
      ey_q    <= end_y_i;
      eh_q    <= end_heading_i;
      first_q <= first_segment_i;
      dx_q    <= 33'(end_x_i) - 33'(start_x_i);
      dy_q    <= 33'(end_y_i) - 33'(start_y_i);
    end
    case (state_q)
      ST_ABS: begin
        adx_q <= dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
        ady_q <= dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
      end
      ST_SQX: sq_q <= sq_prod;
      ST_SQY: sq_q <= sq_q + sq_prod;
      ST_SQRT_WAIT: if (sqrt_done) len_q <= root;
      ST_NDIV_WAIT: begin
        if (div_done) begin
          if (div_quo > DW'(MAX_STEPS_P)) begin
            n_q     <= NW'(MAX_STEPS_P);
            clamp_q <= 1'b1;
          end else begin
            n_q     <= div_quo[NW-1:0];
            clamp_q <= 1'b0;
          end
        end
      end
      ST_XDIV_WAIT: begin
        if (div_done) begin
          q0x_q <= div_quo[32:0];
          r0x_q <= {div_rem[NW-1:0], 1'b0};
        end
      end
      ST_YDIV_WAIT: begin
        if (div_done) begin
          q0y_q <= div_quo[32:0];
          r0y_q <= {div_rem[NW-1:0], 1'b0};
        end
      end
      ST_CORD_GO: begin
        i_q  <= '0;
        qx_q <= '0;
        qy_q <= '0;
        rx_q <= {1'b0, n_q};
        ry_q <= {1'b0, n_q};
      end
      ST_CORD_WAIT: if (cord_done) head_q <= cord_head;
      ST_EMIT_PT: begin
        if (out_free) begin
          i_q  <= i_n;
          qx_q <= qx_n;
          qy_q <= qy_n;
          rx_q <= gex ? (NW+1)'(rsx - {1'b0, twon}) : rsx[NW:0];
          ry_q <= gey ? (NW+1)'(rsy - {1'b0, twon}) : rsy[NW:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (load_start || load_end || load_pt) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_start) begin
      pose_x_q <= sx_q;
      pose_y_q <= sy_q;
      pose_h_q <= sh_q;
      last_q   <= 1'b0;
      cl_q     <= 1'b0;
    end else if (load_end) begin
      pose_x_q <= ex_q;
      pose_y_q <= ey_q;
      pose_h_q <= eh_q;
      last_q   <= 1'b1;
      cl_q     <= 1'b0;
    end else if (load_pt) begin
      pose_x_q <= sx_q + offx;
      pose_y_q <= sy_q + offy;
      pose_h_q <= head_q;
      last_q   <= (i_n == n_q);
      cl_q     <= clamp_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pose_x_o        = pose_x_q;
  assign pose_y_o        = pose_y_q;
  assign pose_heading_o  = pose_h_q;
  assign last_of_run_o   = last_q;
  assign steps_clamped_o = cl_q;

endmodule

`default_nettype wire

>>> rtl/spi_isqrt.sv
`default_nettype none

module spi_isqrt
  import spi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [65:0] rad_i,
  output logic      [32:0] root_o,
  output logic             done_o
);

  logic [65:0] rad_q;
  logic [34:0] rem_q;
  logic [32:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [36:0] sh;
  logic [36:0] trial;
  logic        take;

  // one root bit per cycle, two radicand bits in
  assign sh    = {rem_q, rad_q[65:64]};
  assign trial = {2'b00, root_q, 2'b01};
  assign take  = (sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[63:0], 2'b00};
      rem_q  <= take ? 35'(sh - trial) : sh[34:0];
      root_q <= {root_q[31:0], take};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/spi_div.sv
`default_nettype none

module spi_div
  import spi_pkg::*;
#(
  parameter int unsigned DW = 34,
  parameter int unsigned VW = RESW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic      [DW-1:0] quo_o,
  output logic      [VW-1:0] rem_o,
  output logic               done_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] a_q;
  logic [VW-1:0] r_q;
  logic [VW-1:0] d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [VW:0]   sh;
  logic          take;

  // restoring division, one quotient bit per cycle
  assign sh   = {r_q, a_q[DW-1]};
  assign take = (sh >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= take ? VW'(sh - {1'b0, d_q}) : sh[VW-1:0];
      a_q <= {a_q[DW-2:0], take};
    end
  end

  assign quo_o  = a_q;
  assign rem_o  = r_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/spi_cordic.sv
`default_nettype none

module spi_cordic
  import spi_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [32:0]   dx_i,
  input  wire logic signed [32:0]   dy_i,
  output logic signed      [HW-1:0] head_o,
  output logic                      done_o
);

  spi_cstate_e state_q, state_d;

  logic signed [CXW-1:0] x_q, y_q;
  logic signed [CZW-1:0] z_q;
  logic [4:0]            i_q;
  logic signed [HW-1:0]  head_q;
  logic                  done_q;

  logic [CXW-1:0]        ay;
  logic [CXW-1:0]        mag;
  logic signed [CXW-1:0] xs, ys;
  logic signed [CZW-1:0] ang;
  logic signed [CZW-1:0] zr;
  logic signed [CXW-1:0] x0, y0;

  // fold into the right half plane
  assign x0 = (dx_i < 0) ? -CXW'(dx_i) : CXW'(dx_i);
  assign y0 = (dx_i < 0) ? -CXW'(dy_i) : CXW'(dy_i);

  assign ay  = (y_q < 0) ? -y_q : y_q;
  assign mag = x_q | ay;
  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign ang = CZW'({1'b0, atan_q30(i_q)});
  assign zr  = (z_q + CZW'(65536)) >>> 17;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CS_FIN);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (start_i) state_d = CS_NORM;
      CS_NORM: if (mag >= (CXW'(1) << 50)) state_d = CS_ITER;
      CS_ITER: if (i_q == 5'd31) state_d = CS_FIN;
      CS_FIN:  state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  // datapath: coarse normalize, then one micro-rotation per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        x_q <= x0;
        y_q <= y0;
        i_q <= '0;
        if (dx_i < 0) z_q <= (dy_i >= 0) ? PI_Q30 : -PI_Q30;
        else          z_q <= '0;
      end
      CS_NORM: begin
        if (mag < (CXW'(1) << 35)) begin
          x_q <= x_q <<< 16;
          y_q <= y_q <<< 16;
        end else if (mag < (CXW'(1) << 47)) begin
          x_q <= x_q <<< 4;
          y_q <= y_q <<< 4;
        end else if (mag < (CXW'(1) << 50)) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end
      end
      CS_ITER: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + ang;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - ang;
        end
        i_q <= i_q + 5'd1;
      end
      CS_FIN: begin
        if (zr > CZW'(HEAD_MAX))       head_q <= HEAD_MAX;
        else if (zr < -CZW'(HEAD_MAX)) head_q <= -HEAD_MAX;
        else                           head_q <= zr[HW-1:0];
      end
      default: ;
    endcase
  end

  assign head_o = head_q;
  assign done_o = done_q;

endmodule

`default_nettype wire
